>>> sv/ccwf_pkg.sv
package ccwf_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxChannelsDef = 512;
  localparam int unsigned SampleBitsDef  = 16;

  // Fixed field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ThrW     = 16;
  localparam int unsigned RunW     = 10;
  localparam int unsigned WinW     = 9;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ThrW-1:0] ThresholdRst = ThrW'(18);
  localparam logic [RunW-1:0] MinLenRst    = RunW'(4);
  localparam logic [RunW-1:0] RunSat       = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_MIN_LEN   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last_channel;
  } item_t;

  typedef struct packed {
    logic            cluster_found;
    logic [WinW-1:0] window_left;
    logic [WinW-1:0] window_right;
    logic            frame_overflow;
  } res_t;

endpackage

>>> sv/ccwf_if.sv
interface ccwf_item_if;
  logic                        valid;
  logic                        ready;
  logic [ccwf_pkg::SampleW-1:0] sample;
  logic                        last_channel;

  modport source (output valid, output sample, output last_channel, input ready);
  modport sink   (input valid, input sample, input last_channel, output ready);
endinterface

interface ccwf_result_if;
  logic                      valid;
  logic                      ready;
  logic                      cluster_found;
  logic [ccwf_pkg::WinW-1:0] window_left;
  logic [ccwf_pkg::WinW-1:0] window_right;
  logic                      frame_overflow;

  modport source (output valid, output cluster_found, output window_left,
                  output window_right, output frame_overflow, input ready);
  modport sink   (input valid, input cluster_found, input window_left,
                  input window_right, input frame_overflow, output ready);
endinterface

interface ccwf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ccwf_pkg::CfgIdxW-1:0]  index;
  logic [ccwf_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/ccwf_in_stage.sv
module ccwf_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  ccwf_item_if.sink         in_i,
  input  logic              advance_i,
  output logic              valid_o,
  output ccwf_pkg::item_t   item_o
);

  logic            valid_q;
  ccwf_pkg::item_t item_q;
  logic            take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.sample       <= in_i.sample;
      item_q.last_channel <= in_i.last_channel;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/ccwf_tracker.sv
module ccwf_tracker #(
  parameter int unsigned MAX_CHANNELS = ccwf_pkg::MaxChannelsDef,
  parameter int unsigned SAMPLE_BITS  = ccwf_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          proc_i,
  input  ccwf_pkg::item_t               item_i,
  input  logic [ccwf_pkg::ThrW-1:0]     threshold_i,
  input  logic [ccwf_pkg::RunW-1:0]     min_len_i,
  output ccwf_pkg::res_t                res_o
);

  localparam int unsigned IdxW   = $clog2(MAX_CHANNELS);
  localparam int unsigned EffW   = (SAMPLE_BITS < ccwf_pkg::SampleW) ? SAMPLE_BITS
                                                                     : ccwf_pkg::SampleW;
  localparam logic [ccwf_pkg::SampleW-1:0] SampleMask =
    ccwf_pkg::SampleW'((64'd1 << EffW) - 64'd1);
  localparam logic [IdxW-1:0] TopIdx = IdxW'(MAX_CHANNELS - 1);

  logic [IdxW-1:0]          idx_q, idx_d;
  logic [ccwf_pkg::RunW-1:0] len_q, len_d;
  logic [IdxW-1:0]          start_q, start_d;
  logic [IdxW-1:0]          end_q, end_d;
  logic                     found_q, found_d;
  logic [IdxW-1:0]          left_q, left_d;
  logic [IdxW-1:0]          right_q, right_d;
  logic                     ovf_q, ovf_d;
  logic                     top_q, top_d;

  logic [ccwf_pkg::SampleW-1:0] smp;
  logic                         hit;
  logic [ccwf_pkg::RunW-1:0]    need;

  // Step values before the frame-end close
  logic [ccwf_pkg::RunW-1:0] s_len;
  logic [IdxW-1:0]           s_start, s_end, s_left, s_right;
  logic                      s_found;
  logic                      frame_close;

  assign smp  = item_i.sample & SampleMask;
  assign hit  = smp > threshold_i;
  assign need = (min_len_i == '0) ? ccwf_pkg::RunW'(1) : min_len_i;

  always_comb begin
    s_len   = len_q;
    s_start = start_q;
    s_end   = end_q;
    s_left  = left_q;
    s_right = right_q;
    s_found = found_q;
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    top_d   = top_q;

    if (top_q) begin
      // Past the last channel slot: flag it, touch nothing else
      ovf_d = 1'b1;
    end else begin
      if (hit) begin
        if (len_q == '0) begin
          s_start = idx_q;
        end
        if (len_q != ccwf_pkg::RunSat) begin
          s_len = len_q + ccwf_pkg::RunW'(1);
        end
        s_end = idx_q;
      end else begin
        if (len_q != '0 && len_q >= need) begin
          if (!found_q) begin
            s_left = start_q;
          end
          s_right = end_q;
          s_found = 1'b1;
        end
        s_len = '0;
      end
      if (idx_q == TopIdx) begin
        top_d = 1'b1;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end

    // Close a run still open at the last channel
    frame_close = s_len != '0 && s_len >= need;
    res_o.cluster_found  = s_found || frame_close;
    res_o.window_left    = ccwf_pkg::WinW'((s_found || !frame_close) ? s_left : s_start);
    res_o.window_right   = ccwf_pkg::WinW'(frame_close ? s_end : s_right);
    res_o.frame_overflow = ovf_d;
    if (!res_o.cluster_found) begin
      res_o.window_left  = '0;
      res_o.window_right = '0;
    end

    len_d   = s_len;
    start_d = s_start;
    end_d   = s_end;
    left_d  = s_left;
    right_d = s_right;
    found_d = s_found;
    if (item_i.last_channel) begin
      // Clear for the next frame
      idx_d   = '0;
      len_d   = '0;
      start_d = '0;
      end_d   = '0;
      left_d  = '0;
      right_d = '0;
      found_d = 1'b0;
      ovf_d   = 1'b0;
      top_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      len_q   <= '0;
      start_q <= '0;
      end_q   <= '0;
      found_q <= 1'b0;
      left_q  <= '0;
      right_q <= '0;
      ovf_q   <= 1'b0;
      top_q   <= 1'b0;
    end else if (proc_i) begin
      idx_q   <= idx_d;
      len_q   <= len_d;
      start_q <= start_d;
      end_q   <= end_d;
      found_q <= found_d;
      left_q  <= left_d;
      right_q <= right_d;
      ovf_q   <= ovf_d;
      top_q   <= top_d;
    end
  end

  a_clear_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && item_i.last_channel |=> idx_q == '0 && len_q == '0 && !found_q && !ovf_q)
    else $error("frame state not cleared after last channel");

  a_ovf_needs_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> top_q)
    else $error("overflow set before the top channel was taken");

  a_open_run_has_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != '0 |-> idx_q != '0 || top_q)
    else $error("open run without any channel taken");

endmodule

>>> sv/ccwf_out_reg.sv
module ccwf_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  ccwf_pkg::res_t  res_i,
  output logic            free_o,
  ccwf_result_if.source   res_o
);

  logic           valid_q;
  ccwf_pkg::res_t res_q;

  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.cluster_found  = res_q.cluster_found;
  assign res_o.window_left    = res_q.window_left;
  assign res_o.window_right   = res_q.window_right;
  assign res_o.frame_overflow = res_q.frame_overflow;

  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result loaded over an untaken result");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.cluster_found |-> res_q.window_left == '0 && res_q.window_right == '0)
    else $error("window reported without a cluster");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not shown");

endmodule

>>> sv/channel_cluster_window_finder.sv
// Channel cluster window finder.
// Feed the channel samples of one board frame on in_i, in channel order, one
// item per channel, with last_channel set on the final one. A sample above the
// threshold register is a hit; a run of at least min_cluster_len hit channels
// is a cluster. On the last channel one result item leaves on res_o: whether a
// cluster was found, the first channel of the first cluster, the last channel
// of the last cluster (both 0 without a cluster) and the overflow flag for a
// frame longer than MAX_CHANNELS. Other channels produce no result.
// Throughput: one item per cycle while no last channel waits on a full result
// register; the per-channel tracking is one compare and counter update between
// the input register and the result register. The last channel's result is
// registered in the result register and held there until it is taken.
// Reset clears the frame state, loads threshold 18 and minimum length 4, and
// leaves both channels empty. When the receiver stalls, channels keep flowing
// until a last channel meets a full result register; then in_i.ready drops
// until the result is taken. Write cfg_i only while no frame is in flight.
module channel_cluster_window_finder #(
  parameter int unsigned MAX_CHANNELS = ccwf_pkg::MaxChannelsDef,
  parameter int unsigned SAMPLE_BITS  = ccwf_pkg::SampleBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ccwf_item_if.sink      in_i,
  ccwf_result_if.source  res_o,
  ccwf_cfg_if.sink       cfg_i
);

  // Configuration registers
  logic [ccwf_pkg::ThrW-1:0] threshold_q;
  logic [ccwf_pkg::RunW-1:0] min_len_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ccwf_pkg::ThresholdRst;
      min_len_q   <= ccwf_pkg::MinLenRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (ccwf_pkg::cfg_reg_e'(cfg_i.index))
        ccwf_pkg::REG_THRESHOLD: threshold_q <= cfg_i.data;
        ccwf_pkg::REG_MIN_LEN:   min_len_q   <= cfg_i.data[ccwf_pkg::RunW-1:0];
        default: ;
      endcase
    end
  end

  logic            item_valid;
  ccwf_pkg::item_t item;
  logic            out_free;
  logic            advance;
  ccwf_pkg::res_t  res;

  // A held item moves on unless it ends a frame and the result slot is busy
  assign advance = item_valid && (!item.last_channel || out_free);

  ccwf_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  ccwf_tracker #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (advance),
    .item_i      (item),
    .threshold_i (threshold_q),
    .min_len_i   (min_len_q),
    .res_o       (res)
  );

  ccwf_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && item.last_channel),
    .res_i  (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

>>> dv/ccwf_checker.sv
module ccwf_checker #(
  parameter int unsigned MaxCh      = ccwf_pkg::MaxChannelsDef,
  parameter int unsigned SampleBits = ccwf_pkg::SampleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccwf_item_if        in_mon,
  ccwf_result_if      res_mon,
  ccwf_cfg_if         cfg_mon,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ccwf_pkg::*;

  localparam logic [SampleW-1:0] SampleMask = SampleW'((64'd1 << SampleBits) - 64'd1);

  // Frame summaries still owed by the block, oldest first
  res_t frame_summaries_q[$];

  logic [ThrW-1:0] thr_q;
  logic [RunW-1:0] min_len_q;

  int unsigned     chan_idx;
  int unsigned     run_first;
  int unsigned     run_last;
  int unsigned     left_edge;
  int unsigned     right_edge;
  logic [RunW-1:0] run_len;
  logic            found;
  logic            ovf;
  logic            top_taken;
  int unsigned     err_cnt;

  function automatic void clear_frame();
    chan_idx   = 0;
    run_first  = 0;
    run_last   = 0;
    left_edge  = 0;
    right_edge = 0;
    run_len    = '0;
    found      = 1'b0;
    ovf        = 1'b0;
    top_taken  = 1'b0;
  endfunction

  // A zero minimum length counts as one
  function automatic void close_run();
    logic [RunW-1:0] need;
    need = (min_len_q == '0) ? RunW'(1) : min_len_q;
    if (run_len != '0 && run_len >= need) begin
      if (!found) left_edge = run_first;
      right_edge = run_last;
      found      = 1'b1;
    end
    run_len = '0;
  endfunction

  function automatic void take_channel(logic [SampleW-1:0] raw, logic last);
    logic [SampleW-1:0] s;
    res_t               summary;
    s = raw & SampleMask;
    if (top_taken) begin
      // channels past the end only raise the overflow flag
      ovf = 1'b1;
    end else begin
      if (s > thr_q) begin
        if (run_len == '0) run_first = chan_idx;
        if (run_len != RunSat) run_len++;
        run_last = chan_idx;
      end else begin
        close_run();
      end
      if (chan_idx >= MaxCh - 1) top_taken = 1'b1;
      else chan_idx++;
    end
    if (last) begin
      close_run();
      summary.cluster_found  = found;
      summary.window_left    = found ? WinW'(left_edge) : '0;
      summary.window_right   = found ? WinW'(right_edge) : '0;
      summary.frame_overflow = ovf;
      frame_summaries_q = {frame_summaries_q, summary};
      clear_frame();
    end
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      thr_q     = ThresholdRst;
      min_len_q = MinLenRst;
      clear_frame();
      frame_summaries_q.delete();
      err_cnt   = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          REG_THRESHOLD: thr_q     = cfg_mon.data[ThrW-1:0];
          REG_MIN_LEN:   min_len_q = cfg_mon.data[RunW-1:0];
          default: ;
        endcase
      end
      // compare before taking this edge's channel: its summary comes later
      if (res_mon.valid && res_mon.ready) begin
        if (frame_summaries_q.size() == 0) begin
          flag_mismatch("unexpected result item", 1, 0);
        end else begin
          want = frame_summaries_q.pop_front();
          if (res_mon.cluster_found !== want.cluster_found)
            flag_mismatch("cluster_found", 32'(res_mon.cluster_found),
                          32'(want.cluster_found));
          if (res_mon.window_left !== want.window_left)
            flag_mismatch("window_left", 32'(res_mon.window_left), 32'(want.window_left));
          if (res_mon.window_right !== want.window_right)
            flag_mismatch("window_right", 32'(res_mon.window_right),
                          32'(want.window_right));
          if (res_mon.frame_overflow !== want.frame_overflow)
            flag_mismatch("frame_overflow", 32'(res_mon.frame_overflow),
                          32'(want.frame_overflow));
        end
      end
      if (in_mon.valid && in_mon.ready)
        take_channel(in_mon.sample, in_mon.last_channel);
    end
    err_cnt_o <= err_cnt;
    pending_o <= frame_summaries_q.size();
  end

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccwf_pkg::*;

  localparam int ClkPeriodNs   = 8;
  localparam int WatchdogLimit = 4000;
  localparam int NumPhases     = 9;
  localparam int PhaseItems    = 60;
  localparam int PhaseFrames   = 2;

  // Shapes of frame content
  typedef enum int {
    FR_RUNS,
    FR_NOISE,
    FR_SOLID
  } frame_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(ClkPeriodNs / 2) clk_i = ~clk_i;

  ccwf_item_if   in_if ();
  ccwf_result_if res_if ();
  ccwf_cfg_if    cfg_if ();

  int unsigned err_cnt;
  int unsigned pending;

  channel_cluster_window_finder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  ccwf_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .res_mon   (res_if),
    .cfg_mon   (cfg_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  // Stimulus-side copy of the settings, used only to aim samples at the
  // threshold and run and frame lengths at the minimum cluster length.
  logic [ThrW-1:0] cur_thr = ThresholdRst;
  logic [RunW-1:0] cur_min = MinLenRst;
  int              sent_items = 0;
  logic            tx_calm = 1'b0;

  // Stall length: mostly short, now and then a long one
  function automatic int pick_hold();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (tx_calm || $urandom_range(0, 1) == 0) return 0;
    return pick_hold();
  endfunction

  // --------------------------------------------------------------------------
  // Result side: ready wanders between stall-heavy and stall-free stretches
  // --------------------------------------------------------------------------
  int   rx_stall     = 0;
  int   rx_mode_left = 0;
  logic rx_calm      = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_calm      = ($urandom_range(0, 3) == 0);
        rx_mode_left = $urandom_range(40, 300);
      end else begin
        rx_mode_left--;
      end
      if (rx_stall > 0) begin
        res_if.ready <= 1'b0;
        rx_stall--;
      end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        rx_stall = pick_hold();
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no channel moves an item for too long
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sample generators, aimed at the current threshold
  // --------------------------------------------------------------------------
  function automatic logic [ThrW-1:0] hit_value();
    if (cur_thr == '1) return '1;  // nothing can exceed the top threshold
    if ($urandom_range(0, 3) == 0) return cur_thr + 1'b1;
    return ThrW'($urandom_range(int'(cur_thr) + 1, 65535));
  endfunction

  function automatic logic [ThrW-1:0] miss_value();
    if ($urandom_range(0, 3) == 0) return cur_thr;
    return ThrW'($urandom_range(0, int'(cur_thr)));
  endfunction

  // Run lengths cluster around the minimum so both sides of it get hit
  function automatic int pick_run_len();
    int need;
    need = (cur_min == '0) ? 1 : int'(cur_min);
    case ($urandom_range(0, 3))
      0:       return (need > 1) ? need - 1 : 1;
      1:       return need;
      2:       return need + 1;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Mostly short frames; some longer ones, a few around the minimum length, a few
  // at, just below or past the channel limit
  function automatic int pick_len();
    int r;
    int need;
    need = (cur_min == '0) ? 1 : int'(cur_min);
    r    = $urandom_range(0, 39);
    if (r < 30) return $urandom_range(1, 32);
    if (r < 35) return $urandom_range(33, 100);
    if (r < 37) return $urandom_range(1, (need + 8 > 600) ? 600 : need + 8);
    if (r == 37) return MaxChannelsDef;
    if (r == 38) return $urandom_range(MaxChannelsDef + 1, MaxChannelsDef + 18);
    return $urandom_range(MaxChannelsDef - 7, MaxChannelsDef - 1);
  endfunction

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return FR_RUNS;
    if (r < 9) return FR_NOISE;
    return FR_SOLID;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one channel after a random gap; hold valid high once accepted so
  // back-to-back items need no second assignment in the same step.
  task automatic send_channel(logic [SampleW-1:0] s, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample       <= s;
    in_if.last_channel <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sent_items++;
  endtask

  task automatic send_seq(logic [SampleW-1:0] vals[$]);
    foreach (vals[i]) send_channel(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_frame(int len, frame_kind_e kind);
    int               seg_left;
    logic             seg_hit;
    logic [SampleW-1:0] s;
    tx_calm  = ($urandom_range(0, 4) == 0);
    seg_left = 0;
    seg_hit  = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      case (kind)
        FR_SOLID: s = hit_value();
        FR_NOISE: begin
          if ($urandom_range(0, 7) == 0) s = $urandom_range(0, 1) ? miss_value() : hit_value();
          else s = SampleW'($urandom());
        end
        default: begin
          // alternate hit runs and miss gaps
          if (seg_left == 0) begin
            seg_hit  = ~seg_hit;
            seg_left = seg_hit ? pick_run_len() : $urandom_range(1, 4);
          end
          seg_left--;
          s = seg_hit ? hit_value() : miss_value();
        end
      endcase
      send_channel(s, i == len - 1);
    end
  endtask

  // Drop valid and wait for every owed result, plus a short settle margin
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Registers change only with the block idle
  task automatic set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_THRESHOLD) cur_thr = data[ThrW-1:0];
    else cur_min = data[RunW-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [SampleW-1:0] seq[$];
    int                 thr_tab[NumPhases];
    int                 min_tab[NumPhases];
    int                 phase_start;
    int                 phase_frames;

    in_if.valid        = 1'b0;
    in_if.sample       = '0;
    in_if.last_channel = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_THRESHOLD;
    cfg_if.data        = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset settings (threshold 18, minimum 4).
    // Two clusters with threshold-equal samples around them: window 1..9.
    seq = {16'd18, 16'd19, 16'd19, 16'd19, 16'd19, 16'd18,
           16'd19, 16'd19, 16'd19, 16'd19, 16'd0};
    send_seq(seq);
    // Run still open on the last channel, full-scale samples: window 0..3
    seq = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_seq(seq);
    // Run one short of the minimum: no cluster, window fields zero
    seq = {16'd19, 16'd19, 16'd19, 16'd0, 16'hFFFF};
    send_seq(seq);
    // One-channel frame
    seq = {16'd0};
    send_seq(seq);
    // Minimum length of zero acts as one: single hits are clusters, window 1..3
    set_reg(REG_MIN_LEN, 16'd0);
    seq = {16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
    send_seq(seq);

    // Settings per phase: defaults restored, threshold extremes, minimum at
    // one, at the frame size, at zero, at full field width, with data bits
    // above the register width set, and random settings in the last two.
    thr_tab = '{18, 0, 65535, 0, 1000, 65534, 300, 0, 0};
    min_tab = '{4, 1, 4, 512, 0, 1023, 'hFC03, 0, 0};
    thr_tab[7] = $urandom_range(0, 65535);
    min_tab[7] = $urandom_range(1, 12);
    thr_tab[8] = $urandom_range(0, 2000);
    min_tab[8] = $urandom_range(1, 6);

    for (int p = 0; p < NumPhases; p++) begin
      set_reg(REG_THRESHOLD, CfgDataW'(thr_tab[p]));
      set_reg(REG_MIN_LEN, CfgDataW'(min_tab[p]));
      phase_start  = sent_items;
      phase_frames = 0;
      if (p == 3) begin
        // a full-length cluster in a frame one past the limit
        send_frame(MaxChannelsDef + 1, FR_SOLID);
      end
      while (sent_items - phase_start < PhaseItems || phase_frames < PhaseFrames) begin
        send_frame(pick_len(), pick_kind());
        phase_frames++;
      end
    end

    // Wait out every owed result, then the block's latency with margin
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
